// ===== src/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and codes for the subscriber table with peak report.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

	// default number of subscriber slots
	localparam int TABLE_DEPTH_DEF = 16;

	// command codes
	localparam logic [2:0] CMD_SUBSCRIBE   = 3'd0;
	localparam logic [2:0] CMD_UNSUBSCRIBE = 3'd1;
	localparam logic [2:0] CMD_LEVEL       = 3'd2;
	localparam logic [2:0] CMD_SECOND      = 3'd3;
	localparam logic [2:0] CMD_SEND        = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_REPORT    = 3'd0;
	localparam logic [2:0] KIND_INSERTED  = 3'd1;
	localparam logic [2:0] KIND_RENEWED   = 3'd2;
	localparam logic [2:0] KIND_FULL      = 3'd3;
	localparam logic [2:0] KIND_REMOVED   = 3'd4;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] client_addr;
		logic [15:0] udp_port;
		logic [15:0] lifetime;
		logic [14:0] play_left;
		logic [14:0] play_right;
		logic [14:0] cap_left;
		logic [14:0] cap_right;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] dest_addr;
		logic [15:0] dest_port;
		logic [14:0] out_left;
		logic [14:0] out_right;
		logic [14:0] in_left;
		logic [14:0] in_right;
		logic        last;
	} result_t;

	// one table slot as stored in the slot memory
	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] remaining;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the incoming item
		logic walk_en;  // issue a slot read and advance the walk index
		logic finish;   // apply the end-of-walk action
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_walk;  // incoming item needs a pass over the table
		logic walk_last;   // current read is the last slot
	} dp_status_t;

endpackage

`default_nettype wire

// ===== src/sbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbt_ctrl
// Sequencer: accepts a command and, if it needs one, walks the slot table, then finishes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  sbt_pkg::dp_status_t status,
	output sbt_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	sbt_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = start && (state_q == sbt_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbt_pkg::ST_IDLE: begin
				if (accept && status.needs_walk) state_d = sbt_pkg::ST_WALK;
			end
			sbt_pkg::ST_WALK: begin
				if (status.walk_last) state_d = sbt_pkg::ST_DRAIN;
			end
			sbt_pkg::ST_DRAIN:  state_d = sbt_pkg::ST_FINISH;
			sbt_pkg::ST_FINISH: state_d = sbt_pkg::ST_IDLE;
			default:            state_d = sbt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.load    = 1'b0;
		cmd.walk_en = 1'b0;
		cmd.finish  = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			sbt_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = accept;
			end
			sbt_pkg::ST_WALK:   cmd.walk_en = 1'b1;
			sbt_pkg::ST_DRAIN:  ;
			sbt_pkg::ST_FINISH: cmd.finish = 1'b1;
			default:            ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sbt_datapath.sv =====
// ----------------------------------------------------------------------------
// sbt_datapath
// Slot memory, valid bits, walk engine, peak registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_datapath #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sbt_pkg::item_t      item,
	input  sbt_pkg::ctrl_cmd_t  ctrl,
	output sbt_pkg::dp_status_t status,
	output sbt_pkg::result_t    result,
	output logic                done
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

	sbt_pkg::entry_t mem [TABLE_DEPTH];

	sbt_pkg::item_t   item_q;
	logic [IW-1:0]    rd_idx_q;
	logic [IW-1:0]    idx_s1;
	logic             vld_s1;
	sbt_pkg::entry_t  rd_data_s1;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]    count_q;
	logic             match_found_q, free_found_q, pend_found_q;
	logic [IW-1:0]    match_idx_q, free_idx_q;
	sbt_pkg::entry_t  pend_q;
	logic [14:0]      pk_ol_q, pk_or_q, pk_il_q, pk_ir_q;
	sbt_pkg::result_t result_q, res_d;
	logic             done_q, res_en;

	logic [2:0]       op;
	logic             ev_s1, hit_s1, free_s1, expire_s1;
	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	sbt_pkg::entry_t  wr_data;

	assign op = item_q.cmd;

	// status toward the controller
	always_comb begin
		status.walk_last = (rd_idx_q == LastIdx);
		case (item.cmd)
			sbt_pkg::CMD_SUBSCRIBE:
				status.needs_walk = (item.udp_port != 16'd0) && (item.lifetime != 16'd0);
			sbt_pkg::CMD_UNSUBSCRIBE:
				status.needs_walk = (item.udp_port != 16'd0);
			sbt_pkg::CMD_SECOND, sbt_pkg::CMD_SEND:
				status.needs_walk = (count_q != '0);
			default:
				status.needs_walk = 1'b0;
		endcase
	end

	// per-slot decode of the read stage
	assign ev_s1     = vld_s1 && valid_q[idx_s1];
	assign hit_s1    = ev_s1 && (rd_data_s1.addr == item_q.client_addr)
	                   && (rd_data_s1.port == item_q.udp_port);
	assign free_s1   = vld_s1 && !valid_q[idx_s1];
	assign expire_s1 = ev_s1 && (op == sbt_pkg::CMD_SECOND)
	                   && (rd_data_s1.remaining <= 16'd1);

	// slot memory write port: aging during the walk, insert/renew at finish
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = idx_s1;
		wr_data = rd_data_s1;
		wr_data.remaining = rd_data_s1.remaining - 16'd1;
		if (ev_s1 && (op == sbt_pkg::CMD_SECOND) && !expire_s1) begin
			wr_en = 1'b1;
		end
		if (ctrl.finish && (op == sbt_pkg::CMD_SUBSCRIBE)
		    && (match_found_q || free_found_q)) begin
			wr_en     = 1'b1;
			wr_idx    = match_found_q ? match_idx_q : free_idx_q;
			wr_data.addr      = item_q.client_addr;
			wr_data.port      = item_q.udp_port;
			wr_data.remaining = item_q.lifetime;
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (ctrl.walk_en) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	// item capture and held report entry
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			item_q <= item;
		end
		if (ctrl.walk_en) begin
			idx_s1 <= rd_idx_q;
		end
		if (ev_s1 && (op == sbt_pkg::CMD_SEND)) begin
			pend_q <= rd_data_s1;
		end
		if (hit_s1 && !match_found_q) begin
			match_idx_q <= idx_s1;
		end
		if (free_s1 && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// walk control, search flags, valid bits and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q      <= '0;
			vld_s1        <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_found_q  <= 1'b0;
			valid_q       <= '0;
			count_q       <= '0;
		end else begin
			vld_s1 <= ctrl.walk_en;
			if (ctrl.load) begin
				rd_idx_q      <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				pend_found_q  <= 1'b0;
			end else if (ctrl.walk_en) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (hit_s1) match_found_q <= 1'b1;
			if (free_s1) free_found_q <= 1'b1;
			if (ev_s1 && (op == sbt_pkg::CMD_SEND)) pend_found_q <= 1'b1;

			if (expire_s1) begin
				valid_q[idx_s1] <= 1'b0;
				count_q         <= count_q - CW'(1);
			end else if (ctrl.finish && (op == sbt_pkg::CMD_SUBSCRIBE)
			             && !match_found_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q             <= count_q + CW'(1);
			end else if (ctrl.finish && (op == sbt_pkg::CMD_UNSUBSCRIBE)
			             && match_found_q) begin
				valid_q[match_idx_q] <= 1'b0;
				count_q              <= count_q - CW'(1);
			end
		end
	end

	// peaks: zero while the table is empty, cleared after a send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_ol_q <= '0;
			pk_or_q <= '0;
			pk_il_q <= '0;
			pk_ir_q <= '0;
		end else if ((count_q == '0) || (ctrl.finish && (op == sbt_pkg::CMD_SEND))) begin
			pk_ol_q <= '0;
			pk_or_q <= '0;
			pk_il_q <= '0;
			pk_ir_q <= '0;
		end else if (ctrl.load && (item.cmd == sbt_pkg::CMD_LEVEL)) begin
			if (item.play_left  > pk_ol_q) pk_ol_q <= item.play_left;
			if (item.play_right > pk_or_q) pk_or_q <= item.play_right;
			if (item.cap_left   > pk_il_q) pk_il_q <= item.cap_left;
			if (item.cap_right  > pk_ir_q) pk_ir_q <= item.cap_right;
		end
	end

	// next result: reports trail the walk by one valid slot so the last is known
	always_comb begin
		res_en            = 1'b0;
		res_d.kind        = sbt_pkg::KIND_REPORT;
		res_d.dest_addr   = pend_q.addr;
		res_d.dest_port   = pend_q.port;
		res_d.out_left    = pk_ol_q;
		res_d.out_right   = pk_or_q;
		res_d.in_left     = pk_il_q;
		res_d.in_right    = pk_ir_q;
		res_d.last        = 1'b0;
		if (ev_s1 && (op == sbt_pkg::CMD_SEND) && pend_found_q) begin
			res_en = 1'b1;
		end
		if (ctrl.finish) begin
			res_d.last = 1'b1;
			case (op)
				sbt_pkg::CMD_SEND: res_en = 1'b1;
				sbt_pkg::CMD_SUBSCRIBE, sbt_pkg::CMD_UNSUBSCRIBE: begin
					res_en          = 1'b1;
					res_d.dest_addr = item_q.client_addr;
					res_d.dest_port = item_q.udp_port;
					res_d.out_left  = '0;
					res_d.out_right = '0;
					res_d.in_left   = '0;
					res_d.in_right  = '0;
					if (op == sbt_pkg::CMD_SUBSCRIBE) begin
						res_d.kind = match_found_q ? sbt_pkg::KIND_RENEWED :
						             free_found_q  ? sbt_pkg::KIND_INSERTED :
						                             sbt_pkg::KIND_FULL;
					end else begin
						res_d.kind = match_found_q ? sbt_pkg::KIND_REMOVED :
						                             sbt_pkg::KIND_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_en) result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_en;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// ===== src/subscriber_table_with_peak_report.sv =====
// ----------------------------------------------------------------------------
// subscriber_table_with_peak_report
// Subscriber table with lifetime aging and per-send peak level reports.
//
// Usage: drive item and raise start; a command transfer happens on the edge
// where start is high and busy is low. Results come out one per cycle on
// result, each marked by a single-cycle done; the receiver cannot stall them.
// Level samples and ignored commands (port or lifetime zero, unknown codes,
// aging or send on an empty table) are taken while idle and leave busy low.
// Subscribe, unsubscribe, second tick and send tick walk every slot through
// the slot memory, which has one read and one write port; busy stays high
// through the walk, drain and finish states. The status result of
// subscribe/unsubscribe is on result in the first cycle with busy low again;
// send reports appear one per valid slot during the walk, trailing by one
// slot, with the final one in that same first idle cycle.
// Reset clears all slot valid bits and the peaks; slot contents need no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module subscriber_table_with_peak_report #(
	parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  sbt_pkg::item_t   item,
	output logic             busy,
	output sbt_pkg::result_t result,
	output logic             done
);

	sbt_pkg::ctrl_cmd_t  ctrl_cmd;
	sbt_pkg::dp_status_t dp_status;

	sbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (dp_status),
		.cmd    (ctrl_cmd),
		.busy   (busy)
	);

	sbt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctrl   (ctrl_cmd),
		.status (dp_status),
		.result (result),
		.done   (done)
	);

	// status results are always single and final
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.kind != sbt_pkg::KIND_REPORT) |-> result.last)
		else $error("status result without last");

	// status results carry zero peaks
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.kind != sbt_pkg::KIND_REPORT) |->
		(result.out_left == '0) && (result.out_right == '0) &&
		(result.in_left == '0) && (result.in_right == '0))
		else $error("status result with nonzero peaks");

	// nothing follows the final result of a command
	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |=> !done)
		else $error("result after last");

	// without a transfer the block stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy)
		else $error("busy without a command");

endmodule

`default_nettype wire

// ===== bench/tb_subscriber_table_with_peak_report.sv =====
// ----------------------------------------------------------------------------
// tb_subscriber_table_with_peak_report
// Self-checking bench for the subscriber table with peak level reports.
// A behavioral copy of the table tracks every accepted command and queues the
// status and report results it should produce; a monitor pops one per done
// strobe and compares every field. Directed sequences cover the empty table,
// field extremes, renewal, aging, peak clearing and a full table, then random
// traffic over a small subscriber pool runs with and without idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_subscriber_table_with_peak_report;

	localparam int DEPTH       = sbt_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 20;

	// unused command codes, ignored by the block
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	sbt_pkg::item_t   cmd_item = '0;
	logic             busy;
	sbt_pkg::result_t result;
	logic             done;

	subscriber_table_with_peak_report i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (cmd_item),
		.busy   (busy),
		.result (result),
		.done   (done)
	);

	always #5 clk = ~clk;

	// shadow copy of the subscriber table and peaks
	logic        sub_valid [DEPTH];
	logic [31:0] sub_addr  [DEPTH];
	logic [15:0] sub_port  [DEPTH];
	logic [15:0] sub_left  [DEPTH];
	logic [14:0] peak_play_l, peak_play_r, peak_cap_l, peak_cap_r;

	sbt_pkg::result_t awaited_results[$];

	int  error_count     = 0;
	int  cycle_count     = 0;
	int  effective_cmds  = 0;
	int  results_seen    = 0;
	int  kind_seen [6];
	bit  gaps_on         = 1'b0;

	logic [31:0] pool_addr [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];

	// ------------------------------------------------------------------
	// shadow table helpers
	// ------------------------------------------------------------------
	function automatic int lookup_slot(logic [31:0] a, logic [15:0] p);
		for (int i = 0; i < DEPTH; i++)
			if (sub_valid[i] && sub_addr[i] == a && sub_port[i] == p)
				return i;
		return -1;
	endfunction

	function automatic int lowest_free_slot();
		for (int i = 0; i < DEPTH; i++)
			if (!sub_valid[i])
				return i;
		return -1;
	endfunction

	function automatic bit table_is_empty();
		for (int i = 0; i < DEPTH; i++)
			if (sub_valid[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [14:0] raise(logic [14:0] pk, logic [14:0] s);
		return (s > pk) ? s : pk;
	endfunction

	function automatic logic [14:0] rand_level();
		return 15'($urandom_range(0, 32767));
	endfunction

	task automatic clear_peaks();
		peak_play_l = '0;
		peak_play_r = '0;
		peak_cap_l  = '0;
		peak_cap_r  = '0;
	endtask

	// apply one accepted command to the shadow table, queue its results
	task automatic apply_command(input sbt_pkg::item_t it);
		sbt_pkg::result_t r;
		int      slot;
		int      last_slot;
		r = '0;
		r.dest_addr = it.client_addr;
		r.dest_port = it.udp_port;
		r.last = 1'b1;
		case (it.cmd)
			sbt_pkg::CMD_SUBSCRIBE: begin
				if (it.udp_port != 0 && it.lifetime != 0) begin
					slot = lookup_slot(it.client_addr, it.udp_port);
					if (slot >= 0) begin
						sub_left[slot] = it.lifetime;
						r.kind = sbt_pkg::KIND_RENEWED;
					end else begin
						slot = lowest_free_slot();
						if (slot >= 0) begin
							sub_valid[slot] = 1'b1;
							sub_addr[slot]  = it.client_addr;
							sub_port[slot]  = it.udp_port;
							sub_left[slot]  = it.lifetime;
							r.kind = sbt_pkg::KIND_INSERTED;
						end else begin
							r.kind = sbt_pkg::KIND_FULL;
						end
					end
					awaited_results.push_back(r);
					effective_cmds++;
				end
			end
			sbt_pkg::CMD_UNSUBSCRIBE: begin
				if (it.udp_port != 0) begin
					slot = lookup_slot(it.client_addr, it.udp_port);
					if (slot >= 0) begin
						sub_valid[slot] = 1'b0;
						r.kind = sbt_pkg::KIND_REMOVED;
					end else begin
						r.kind = sbt_pkg::KIND_NOT_FOUND;
					end
					awaited_results.push_back(r);
					if (table_is_empty())
						clear_peaks();
					effective_cmds++;
				end
			end
			sbt_pkg::CMD_LEVEL: begin
				if (!table_is_empty()) begin
					peak_play_l = raise(peak_play_l, it.play_left);
					peak_play_r = raise(peak_play_r, it.play_right);
					peak_cap_l  = raise(peak_cap_l, it.cap_left);
					peak_cap_r  = raise(peak_cap_r, it.cap_right);
					effective_cmds++;
				end
			end
			sbt_pkg::CMD_SECOND: begin
				if (!table_is_empty())
					effective_cmds++;
				for (int i = 0; i < DEPTH; i++) begin
					if (sub_valid[i]) begin
						if (sub_left[i] <= 1)
							sub_valid[i] = 1'b0;
						else
							sub_left[i] = sub_left[i] - 16'd1;
					end
				end
				if (table_is_empty())
					clear_peaks();
			end
			sbt_pkg::CMD_SEND: begin
				last_slot = -1;
				for (int i = 0; i < DEPTH; i++)
					if (sub_valid[i])
						last_slot = i;
				if (last_slot >= 0)
					effective_cmds++;
				for (int i = 0; i < DEPTH; i++) begin
					if (sub_valid[i]) begin
						r = '0;
						r.kind      = sbt_pkg::KIND_REPORT;
						r.dest_addr = sub_addr[i];
						r.dest_port = sub_port[i];
						r.out_left  = peak_play_l;
						r.out_right = peak_play_r;
						r.in_left   = peak_cap_l;
						r.in_right  = peak_cap_r;
						r.last      = (i == last_slot);
						awaited_results.push_back(r);
					end
				end
				clear_peaks();
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// command transfer, with optional idle burst afterwards
	// ------------------------------------------------------------------
	task automatic issue_command(input sbt_pkg::item_t it);
		int gap;
		cmd_item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_command(it);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 19);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic sbt_pkg::item_t random_fill();
		sbt_pkg::item_t it;
		it.cmd         = 3'($urandom_range(0, 7));
		it.client_addr = $urandom();
		it.udp_port    = 16'($urandom());
		it.lifetime    = 16'($urandom());
		it.play_left   = rand_level();
		it.play_right  = rand_level();
		it.cap_left    = rand_level();
		it.cap_right   = rand_level();
		return it;
	endfunction

	function automatic sbt_pkg::item_t make_cmd(logic [2:0] op, logic [31:0] a,
			logic [15:0] p, logic [15:0] l);
		sbt_pkg::item_t it;
		it = random_fill();
		it.cmd = op;
		it.client_addr = a;
		it.udp_port = p;
		it.lifetime = l;
		return it;
	endfunction

	function automatic sbt_pkg::item_t make_level(logic [14:0] pl, logic [14:0] pr,
			logic [14:0] cl, logic [14:0] cr);
		sbt_pkg::item_t it;
		it = random_fill();
		it.cmd = sbt_pkg::CMD_LEVEL;
		it.play_left = pl;
		it.play_right = pr;
		it.cap_left = cl;
		it.cap_right = cr;
		return it;
	endfunction

	function automatic sbt_pkg::item_t make_plain(logic [2:0] op);
		sbt_pkg::item_t it;
		it = random_fill();
		it.cmd = op;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic note_error(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_error($sformatf("result %0d %s got %0h expected %0h",
				results_seen, name, got, want));
	endtask

	always @(posedge clk) begin
		sbt_pkg::result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				note_error($sformatf("result %0d arrived with nothing pending, kind %0d",
					results_seen, result.kind));
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", 32'(result.kind), 32'(want.kind));
				check_field("dest_addr", result.dest_addr, want.dest_addr);
				check_field("dest_port", 32'(result.dest_port), 32'(want.dest_port));
				check_field("out_left", 32'(result.out_left), 32'(want.out_left));
				check_field("out_right", 32'(result.out_right), 32'(want.out_right));
				check_field("in_left", 32'(result.in_left), 32'(want.in_left));
				check_field("in_right", 32'(result.in_right), 32'(want.in_right));
				check_field("last", 32'(result.last), 32'(want.last));
				if (want.kind <= sbt_pkg::KIND_NOT_FOUND)
					kind_seen[want.kind]++;
			end
			results_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[subscriber_table_with_peak_report] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// everything on an empty table: ignored codes, not found, no reports
	task automatic test_idle_table();
		issue_command(make_plain(sbt_pkg::CMD_SEND));
		issue_command(make_plain(sbt_pkg::CMD_SECOND));
		issue_command(make_level(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF));
		issue_command(make_cmd(sbt_pkg::CMD_UNSUBSCRIBE, 32'hA5A5A5A5, 16'h8000, 16'd7));
		issue_command(make_plain(CMD_SPARE_5));
		issue_command(make_plain(CMD_SPARE_6));
		issue_command(make_plain(CMD_SPARE_7));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h0A000001, 16'd0, 16'd10));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h0A000001, 16'd5, 16'd0));
		issue_command(make_cmd(sbt_pkg::CMD_UNSUBSCRIBE, 32'h0A000001, 16'd0, 16'd10));
	endtask

	// address, port and lifetime extremes; same address on two ports; renewal
	task automatic test_subscribe_extremes();
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h0, 16'd1, 16'd1));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'hFFFFFFFF, 16'd1, 16'd2));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h0, 16'd1, 16'd3));
	endtask

	// peaks rise per channel, a lower sample does not pull them down,
	// a send clears them
	task automatic test_levels_and_reports();
		issue_command(make_level(15'h7FFF, 15'h0, 15'h7FFF, 15'h0));
		issue_command(make_level(15'h0, 15'h7FFF, 15'h0, 15'h7FFF));
		issue_command(make_level(rand_level(), rand_level(), rand_level(), rand_level()));
		issue_command(make_plain(sbt_pkg::CMD_SEND));
		issue_command(make_plain(sbt_pkg::CMD_SEND));
	endtask

	// removal, slot reuse, countdown to expiry, peaks cleared on empty table
	task automatic test_aging();
		issue_command(make_cmd(sbt_pkg::CMD_UNSUBSCRIBE, 32'hFFFFFFFF, 16'hFFFF, 16'd0));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h80000001, 16'h8000, 16'd1));
		issue_command(make_level(15'h1234, 15'h0F0F, 15'h7000, 15'h0001));
		issue_command(make_plain(sbt_pkg::CMD_SECOND));
		issue_command(make_plain(sbt_pkg::CMD_SEND));
		issue_command(make_level(15'h2AAA, 15'h5555, 15'h7FFE, 15'h3FFF));
		issue_command(make_plain(sbt_pkg::CMD_SECOND));
		issue_command(make_plain(sbt_pkg::CMD_SECOND));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h7F000001, 16'd9000, 16'd1));
		issue_command(make_level(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF));
		issue_command(make_cmd(sbt_pkg::CMD_UNSUBSCRIBE, 32'h7F000001, 16'd9000, 16'd1));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, 32'h7F000001, 16'd9000, 16'd1));
		issue_command(make_plain(sbt_pkg::CMD_SEND));
	endtask

	// fill every slot, overflow, full-table send, renew and refill a hole
	task automatic test_table_full();
		logic [31:0] fa [DEPTH + 1];
		logic [15:0] fp [DEPTH + 1];
		for (int i = 0; i <= DEPTH; i++) begin
			fa[i] = $urandom();
			fp[i] = 16'($urandom_range(1, 65535));
			issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, fa[i], fp[i], 16'd3));
		end
		issue_command(make_level(rand_level(), rand_level(), rand_level(), rand_level()));
		issue_command(make_plain(sbt_pkg::CMD_SEND));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, fa[0], fp[0], 16'd1));
		issue_command(make_cmd(sbt_pkg::CMD_UNSUBSCRIBE, fa[1], fp[1], 16'd0));
		issue_command(make_cmd(sbt_pkg::CMD_SUBSCRIBE, $urandom(),
			16'($urandom_range(1, 65535)), 16'd3));
		repeat (3) issue_command(make_plain(sbt_pkg::CMD_SECOND));
	endtask

	function automatic logic [15:0] pick_lifetime();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 16'($urandom_range(1, 6));
		else if (r < 9)
			return 16'($urandom_range(7, 50));
		return 16'($urandom_range(1, 65535));
	endfunction

	// random mix over a small pool of subscribers so that renewals,
	// removals and overflows keep happening
	task automatic test_random_traffic(input int target, input bit with_gaps);
		sbt_pkg::item_t it;
		int    pick;
		int    idx;
		gaps_on = with_gaps;
		for (int n = 0; n < target; n++) begin
			pick = $urandom_range(0, 99);
			it = random_fill();
			idx = $urandom_range(0, POOL_SIZE - 1);
			if (pick < 36) begin
				it.cmd = sbt_pkg::CMD_SUBSCRIBE;
				if ($urandom_range(0, 6) != 0) begin
					it.client_addr = pool_addr[idx];
					it.udp_port    = pool_port[idx];
				end else begin
					it.udp_port = 16'($urandom_range(1, 65535));
				end
				it.lifetime = pick_lifetime();
			end else if (pick < 51) begin
				it.cmd = sbt_pkg::CMD_UNSUBSCRIBE;
				if ($urandom_range(0, 4) != 0) begin
					it.client_addr = pool_addr[idx];
					it.udp_port    = pool_port[idx];
				end else begin
					it.udp_port = 16'($urandom_range(1, 65535));
				end
			end else if (pick < 75) begin
				it.cmd = sbt_pkg::CMD_LEVEL;
			end else if (pick < 86) begin
				it.cmd = sbt_pkg::CMD_SECOND;
			end else if (pick < 97) begin
				it.cmd = sbt_pkg::CMD_SEND;
			end else begin
				// noise: port or lifetime zero, or an unused code
				case ($urandom_range(0, 3))
					0: begin
						it.cmd = sbt_pkg::CMD_SUBSCRIBE;
						it.udp_port = '0;
					end
					1: begin
						it.cmd = sbt_pkg::CMD_SUBSCRIBE;
						it.udp_port = 16'($urandom_range(1, 65535));
						it.lifetime = '0;
					end
					2: begin
						it.cmd = sbt_pkg::CMD_UNSUBSCRIBE;
						it.udp_port = '0;
					end
					default: it.cmd = 3'($urandom_range(5, 7));
				endcase
			end
			issue_command(it);
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < 6; i++)
			kind_seen[i] = 0;
		for (int i = 0; i < DEPTH; i++) begin
			sub_valid[i] = 1'b0;
			sub_addr[i]  = '0;
			sub_port[i]  = '0;
			sub_left[i]  = '0;
		end
		clear_peaks();
		// pool entries 4 to 7 reuse the addresses of entries 0 to 3 with other ports
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_addr[i] = (i >= 4 && i < 8) ? pool_addr[i - 4] : $urandom();
			pool_port[i] = 16'($urandom_range(1, 65535));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		gaps_on = 1'b1;
		test_idle_table();
		test_subscribe_extremes();
		test_levels_and_reports();
		test_aging();
		test_table_full();
		test_random_traffic(150, 1'b1);
		test_random_traffic(53, 1'b0);

		// drain outstanding results, then watch for strays
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("run covered %0d effective commands and %0d results in %0d cycles",
			effective_cmds, results_seen, cycle_count);
		$display("reports %0d, inserted %0d, renewed %0d, full %0d, removed %0d, not found %0d",
			kind_seen[sbt_pkg::KIND_REPORT], kind_seen[sbt_pkg::KIND_INSERTED],
			kind_seen[sbt_pkg::KIND_RENEWED], kind_seen[sbt_pkg::KIND_FULL],
			kind_seen[sbt_pkg::KIND_REMOVED], kind_seen[sbt_pkg::KIND_NOT_FOUND]);
		if (error_count == 0)
			$display("[subscriber_table_with_peak_report] OK");
		else
			$display("[subscriber_table_with_peak_report] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/sbt_pkg.sv
src/sbt_ctrl.sv
src/sbt_datapath.sv
src/subscriber_table_with_peak_report.sv
bench/tb_subscriber_table_with_peak_report.sv
